/* rtl/core/dlkl_pkg.sv */
// Package for the doubly linked key list: sizes, command and status codes,
// controller state type and the controller/datapath interface structs.
// No dependencies.
package dlkl_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   localparam logic [2:0] CMD_INSERT     = 3'd0;
   localparam logic [2:0] CMD_DELETE_KEY = 3'd1;
   localparam logic [2:0] CMD_DEL_FIRST  = 3'd2;
   localparam logic [2:0] CMD_DEL_LAST   = 3'd3;
   localparam logic [2:0] CMD_DUMP       = 3'd4;

   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_A,
      ST_INS_B,
      ST_READ,
      ST_CHECK,
      ST_RESP,
      ST_DUMP_OUT
   } dlkl_state_type;

   typedef struct packed {
      logic       accept;     // capture key, start walk
      logic       use_tail;   // start walk at the tail
      logic       ins_a;      // link old head back to new slot
      logic       ins_b;      // fill new slot, make it head
      logic       unlink;     // remove current slot
      logic       advance;    // step to next slot
      logic       load_rsp;   // load result word
      logic       rsp_elem;   // result carries element key
      logic [1:0] rsp_status;
   } dlkl_cmd_type;

   typedef struct packed {
      logic occ_zero;
      logic full;
      logic key_match;
      logic last_elem;
   } dlkl_stat_type;

endpackage

/* rtl/core/dlkl_ctrl.sv */
// Controller state machine for the doubly linked key list.
// Depends on dlkl_pkg.
module dlkl_ctrl
   import dlkl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [2:0]    req_command,
   input  logic          rsp_ready,
   input  dlkl_stat_type stat,
   output logic          req_ready,
   output logic          rsp_valid,
   output dlkl_cmd_type  cmd
);

   dlkl_state_type state_ff, state_in;
   logic [2:0]     command_ff, command_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         command_ff <= CMD_INSERT;
      end else begin
         state_ff   <= state_in;
         command_ff <= command_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      command_in = command_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               command_in = req_command;
               case (req_command)
                  CMD_INSERT:     state_in = stat.full ? ST_RESP : ST_INS_A;
                  CMD_DELETE_KEY,
                  CMD_DEL_FIRST,
                  CMD_DEL_LAST,
                  CMD_DUMP:       state_in = stat.occ_zero ? ST_RESP : ST_READ;
                  default:        state_in = ST_RESP;
               endcase
            end
         end
         ST_INS_A: state_in = ST_INS_B;
         ST_INS_B: state_in = ST_RESP;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            case (command_ff)
               CMD_DELETE_KEY: begin
                  if (stat.key_match || stat.last_elem) state_in = ST_RESP;
                  else state_in = ST_READ;
               end
               CMD_DUMP: state_in = ST_DUMP_OUT;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         ST_DUMP_OUT: begin
            if (rsp_ready) state_in = stat.last_elem ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept   = 1'b1;
               cmd.use_tail = (req_command == CMD_DEL_LAST);
               case (req_command)
                  CMD_INSERT: begin
                     cmd.load_rsp   = stat.full;
                     cmd.rsp_status = STAT_FULL;
                  end
                  CMD_DELETE_KEY,
                  CMD_DEL_FIRST,
                  CMD_DEL_LAST,
                  CMD_DUMP: begin
                     cmd.load_rsp   = stat.occ_zero;
                     cmd.rsp_status = STAT_NOT_FOUND;
                  end
                  default: begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = STAT_DONE;
                  end
               endcase
            end
         end
         ST_INS_A: cmd.ins_a = 1'b1;
         ST_INS_B: begin
            cmd.ins_b      = 1'b1;
            cmd.load_rsp   = 1'b1;
            cmd.rsp_status = STAT_DONE;
         end
         ST_CHECK: begin
            case (command_ff)
               CMD_DELETE_KEY: begin
                  if (stat.key_match) begin
                     cmd.unlink     = 1'b1;
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = STAT_DONE;
                  end else if (stat.last_elem) begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = STAT_NOT_FOUND;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
               CMD_DUMP: begin
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_elem   = 1'b1;
                  cmd.rsp_status = STAT_DONE;
               end
               default: begin
                  cmd.unlink     = 1'b1;
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_status = STAT_DONE;
               end
            endcase
         end
         ST_RESP: rsp_valid = 1'b1;
         ST_DUMP_OUT: begin
            rsp_valid = 1'b1;
            cmd.advance = rsp_ready && !stat.last_elem;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/dlkl_dp.sv */
// Datapath for the doubly linked key list: key and link memories, free map,
// head, tail, occupancy, walk pointer and result word. Depends on dlkl_pkg.
module dlkl_dp
   import dlkl_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  dlkl_cmd_type                cmd,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   output dlkl_stat_type               stat,
   output logic [1:0]                  rsp_status,
   output logic signed [KEY_WIDTH-1:0] rsp_element_key,
   output logic [CNT_W-1:0]            rsp_element_count,
   output logic                        rsp_last
);

   logic [KEY_WIDTH-1:0] key_mem  [CAPACITY];
   logic [SLOT_W-1:0]    next_mem [CAPACITY];
   logic [SLOT_W-1:0]    prev_mem [CAPACITY];

   logic [CAPACITY-1:0]  free_ff, free_in;
   logic [SLOT_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_rd_ff;
   logic [SLOT_W-1:0]    next_rd_ff, prev_rd_ff;
   logic [1:0]           status_ff;
   logic [KEY_WIDTH-1:0] elem_key_ff;
   logic                 last_ff;

   logic [SLOT_W-1:0]    free_slot;
   logic                 next_we, prev_we;
   logic [SLOT_W-1:0]    next_wa, next_wd, prev_wa, prev_wd;
   logic [CNT_W-1:0]     idx_inc;

   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) free_slot = SLOT_W'(i);
      end
   end

   assign idx_inc        = idx_ff + CNT_W'(1);
   assign stat.occ_zero  = (occ_ff == '0);
   assign stat.full      = (occ_ff == CNT_W'(CAPACITY));
   assign stat.key_match = (key_rd_ff == key_ff);
   assign stat.last_elem = (idx_inc == occ_ff);

   // link writes: insert or unlink, never both
   always_comb begin
      next_we = 1'b0;
      next_wa = free_slot;
      next_wd = stat.occ_zero ? '0 : head_ff;
      prev_we = 1'b0;
      prev_wa = free_slot;
      prev_wd = '0;
      if (cmd.ins_a) begin
         prev_we = !stat.occ_zero;
         prev_wa = head_ff;
         prev_wd = free_slot;
      end else if (cmd.ins_b) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end else if (cmd.unlink) begin
         next_we = (cur_ff != head_ff);
         next_wa = prev_rd_ff;
         next_wd = next_rd_ff;
         prev_we = (cur_ff != tail_ff);
         prev_wa = next_rd_ff;
         prev_wd = prev_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_b) key_mem[free_slot] <= key_ff;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      key_rd_ff  <= key_mem[cur_ff];
      next_rd_ff <= next_mem[cur_ff];
      prev_rd_ff <= prev_mem[cur_ff];
   end

   always_comb begin
      free_in = free_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      if (cmd.accept) begin
         cur_in = cmd.use_tail ? tail_ff : head_ff;
         idx_in = '0;
      end
      if (cmd.ins_b) begin
         free_in[free_slot] = 1'b0;
         head_in = free_slot;
         if (stat.occ_zero) tail_in = free_slot;
         occ_in  = occ_ff + CNT_W'(1);
      end
      if (cmd.unlink) begin
         free_in[cur_ff] = 1'b1;
         if (cur_ff == head_ff) head_in = next_rd_ff;
         if (cur_ff == tail_ff) tail_in = prev_rd_ff;
         occ_in = occ_ff - CNT_W'(1);
      end
      if (cmd.advance) begin
         cur_in = next_rd_ff;
         idx_in = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         cur_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         free_ff <= free_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         cur_ff  <= cur_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) key_ff <= req_key;
      if (cmd.load_rsp) begin
         status_ff   <= cmd.rsp_status;
         elem_key_ff <= cmd.rsp_elem ? key_rd_ff : '0;
         last_ff     <= cmd.rsp_elem ? stat.last_elem : 1'b1;
      end
   end

   // count is stable while a word waits, so it is shown straight from occupancy
   assign rsp_status        = status_ff;
   assign rsp_element_key   = elem_key_ff;
   assign rsp_element_count = occ_ff;
   assign rsp_last          = last_ff;

endmodule

/* rtl/core/doubly_linked_key_list.sv */
// Top level of the doubly linked key list: controller and datapath.
// Depends on dlkl_pkg, dlkl_ctrl, dlkl_dp.
//
//  channel | ports                                  | direction
//  req     | req_valid req_ready req_command req_key | in
//  rsp     | rsp_valid rsp_ready rsp_status          | out
//          | rsp_element_key rsp_element_count      |
//          | rsp_last                               |
//
// Insert: INS_A links old head back, INS_B fills new slot as head; delete
// first/last: READ, CHECK (unlink); by key: READ, CHECK per element visited
// (walk through the link memory, one registered read per step); dump: READ,
// CHECK, DUMP_OUT per element plus rsp stalls; other commands, empty/full:
// RESP. One word at a time; req is held off until the last result word is
// taken. Reset is synchronous, frees every slot at once; no clearing pass.
module doubly_linked_key_list
   import dlkl_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_command,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic signed [KEY_WIDTH-1:0] rsp_element_key,
   output logic [CNT_W-1:0]            rsp_element_count,
   output logic                        rsp_last
);

   dlkl_cmd_type  cmd;
   dlkl_stat_type stat;

   dlkl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd)
   );

   dlkl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_key           (req_key),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_element_key   (rsp_element_key),
      .rsp_element_count (rsp_element_count),
      .rsp_last          (rsp_last)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken while result pending");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_element_count <= CNT_W'(CAPACITY)) else $error("occupancy overflow");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not idle after last word");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accepted twice");

endmodule
